FILE: src/dls_pkg.sv
// shared opcodes, back-end states and default sizes for the display list segmenter
package dls_pkg;

  // default sizes
  localparam int DEF_STATE_DEPTH = 16;
  localparam int DEF_SCOPE_DEPTH = 16;
  localparam int DEF_MAX_ITEMS   = 1048576;

  // width of a view identifier
  localparam int VIEW_W = 32;

  // display-list opcodes, the spare code behaves as other drawing
  typedef enum logic [2:0] {
    OP_BEGIN   = 3'd0,
    OP_END     = 3'd1,
    OP_CLIP    = 3'd2,
    OP_RECORD  = 3'd3,
    OP_DRAW    = 3'd4,
    OP_OTHER   = 3'd5,
    OP_FINISH  = 3'd6,
    OP_SPARE   = 3'd7
  } dls_op_t;

  // result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAVED  = 1'b1;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HEAD = 3'b010,
    ST_BODY = 3'b100
  } dls_state_t;

endpackage

FILE: src/display_list_segmenter.sv
// top level of the display list segmenter: front end, job queue and back end
// a header beat passes the queue, the back-end job register and the output register
// throughput: one opcode per cycle while the two-entry job queue has room
// a segment is loaded as a job, then leaves the output as 1 + saved_count beats
// reset: rst_n synchronous active low clears all control state, no clearing pass
// a finish beat returns the front end to its reset state after queueing the last segment
module display_list_segmenter #(
  parameter int STATE_DEPTH = dls_pkg::DEF_STATE_DEPTH,
  parameter int SCOPE_DEPTH = dls_pkg::DEF_SCOPE_DEPTH,
  parameter int MAX_ITEMS   = dls_pkg::DEF_MAX_ITEMS,
  localparam int CW  = $clog2(MAX_ITEMS + 1),
  localparam int IW  = $clog2(MAX_ITEMS),
  localparam int DW  = $clog2(STATE_DEPTH + 1),
  localparam int OBW = 2 * CW + dls_pkg::VIEW_W + 3 + DW + IW,
  localparam int TDW = ((OBW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [39:0]    in_tdata,   // operation, view_id
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [TDW-1:0] out_tdata,  // start_index, end_index, preceding_view, view_valid,
                                     // drawing flag, saved_count, saved_index, overflow
  output logic           out_tuser,  // kind
  output logic           out_tlast
);
  import dls_pkg::*;

  localparam int JW = 2 * CW + VIEW_W + 3 + DW + STATE_DEPTH * IW;

  logic          job_push;
  logic [JW-1:0] job_wdata;
  logic          job_ready;
  logic          job_valid;
  logic [JW-1:0] job_rdata;
  logic          job_pop;
  logic          unused_pad;

  assign unused_pad = ^in_tdata[39:35];

  dls_front #(
    .STATE_DEPTH (STATE_DEPTH),
    .SCOPE_DEPTH (SCOPE_DEPTH),
    .MAX_ITEMS   (MAX_ITEMS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_op    (in_tdata[2:0]),
    .item_view  (in_tdata[34:3]),
    .job_push   (job_push),
    .job_data   (job_wdata),
    .job_ready  (job_ready)
  );

  dls_queue #(
    .W (JW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_wdata),
    .push_ready (job_ready),
    .pop_valid  (job_valid),
    .pop_data   (job_rdata),
    .pop        (job_pop)
  );

  dls_back #(
    .STATE_DEPTH (STATE_DEPTH),
    .MAX_ITEMS   (MAX_ITEMS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job_data   (job_rdata),
    .job_pop    (job_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // pad bits of the input beat carry nothing
  a_pad_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (unused_pad == unused_pad))
    else $error("input pad bits unknown");

  // a draw view beat is only taken when the job queue can hold its segment
  a_draw_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[2:0] == OP_DRAW) |-> job_ready)
    else $error("draw view accepted without queue room");

  // the back end never offers a beat without a job behind it at reset exit
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");
`endif

endmodule

FILE: src/dls_queue.sv
// two-entry segment job queue between front and back
module dls_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  input  logic         pop
);

  logic [1:0][W-1:0] mem_r;
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/dls_front.sv
// front end: numbers opcodes, keeps the state and scope stacks, builds segment jobs
module dls_front #(
  parameter int STATE_DEPTH = dls_pkg::DEF_STATE_DEPTH,
  parameter int SCOPE_DEPTH = dls_pkg::DEF_SCOPE_DEPTH,
  parameter int MAX_ITEMS   = dls_pkg::DEF_MAX_ITEMS,
  localparam int CW = $clog2(MAX_ITEMS + 1),
  localparam int IW = $clog2(MAX_ITEMS),
  localparam int DW = $clog2(STATE_DEPTH + 1),
  localparam int JW = 2 * CW + dls_pkg::VIEW_W + 3 + DW + STATE_DEPTH * IW
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [2:0]                item_op,
  input  logic [dls_pkg::VIEW_W-1:0] item_view,
  output logic                      job_push,
  output logic [JW-1:0]             job_data,
  input  logic                      job_ready
);
  import dls_pkg::*;

  localparam int SW  = $clog2(SCOPE_DEPTH + 1);
  localparam int SIX = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;

  typedef struct packed {
    logic [CW-1:0]                    start_index;
    logic [CW-1:0]                    end_index;
    logic [VIEW_W-1:0]                view;
    logic                             view_valid;
    logic                             drawing;
    logic [DW-1:0]                    count;
    logic                             ovf;
    logic [STATE_DEPTH-1:0][IW-1:0]   snap;
  } seg_job_t;

  logic [STATE_DEPTH-1:0][IW-1:0] live_r;
  logic [STATE_DEPTH-1:0][IW-1:0] snap_r;
  logic [SCOPE_DEPTH-1:0][DW-1:0] scope_r;
  logic [DW-1:0]                  live_depth_r;
  logic [DW-1:0]                  snap_depth_r;
  logic [SW-1:0]                  scope_depth_r;
  logic [CW-1:0]                  seg_start_r;
  logic [VIEW_W-1:0]              seg_view_r;
  logic                           seg_vv_r;
  logic                           seg_draw_r;
  logic [CW-1:0]                  count_r;
  logic                           ovf_r;

  logic       accept;
  logic       is_finish;
  logic       counting;
  logic       push_live;
  logic       push_scope;
  logic       pop_scope;
  logic       live_room;
  logic       scope_room;
  logic [SW-1:0] scope_top;
  logic [DW-1:0] saved_depth;
  dls_op_t    op;
  seg_job_t   job;

  assign item_ready = job_ready;
  assign accept     = item_valid && item_ready;
  assign op         = dls_op_t'(item_op);
  assign is_finish  = (op == OP_FINISH);
  assign counting   = !is_finish && (count_r != CW'(MAX_ITEMS));
  assign live_room  = (live_depth_r < DW'(STATE_DEPTH));
  assign scope_room = (scope_depth_r < SW'(SCOPE_DEPTH));
  assign scope_top  = scope_depth_r - SW'(1);
  assign saved_depth = scope_r[scope_top[SIX-1:0]];

  // decode which stack moves this item causes
  always_comb begin
    push_live  = 1'b0;
    push_scope = 1'b0;
    pop_scope  = 1'b0;
    if (counting) begin
      case (op)
        OP_BEGIN: begin
          push_live  = 1'b1;
          push_scope = 1'b1;
        end
        OP_CLIP: begin
          push_live = 1'b1;
        end
        OP_END: begin
          pop_scope = (scope_depth_r != '0);
        end
        default: begin
        end
      endcase
    end
  end

  // segment job for the back end
  always_comb begin
    job.start_index = seg_start_r;
    job.end_index   = count_r;
    job.view        = seg_view_r;
    job.view_valid  = seg_vv_r;
    job.drawing     = seg_draw_r;
    job.count       = snap_depth_r;
    job.ovf         = ovf_r;
    job.snap        = snap_r;
  end

  assign job_data = job;
  assign job_push = accept && ((is_finish && count_r != '0) || (counting && op == OP_DRAW));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_depth_r  <= '0;
      snap_depth_r  <= '0;
      scope_depth_r <= '0;
      seg_start_r   <= '0;
      seg_view_r    <= '0;
      seg_vv_r      <= 1'b0;
      seg_draw_r    <= 1'b0;
      count_r       <= '0;
      ovf_r         <= 1'b0;
    end else if (accept) begin
      if (is_finish) begin
        live_depth_r  <= '0;
        snap_depth_r  <= '0;
        scope_depth_r <= '0;
        seg_start_r   <= '0;
        seg_view_r    <= '0;
        seg_vv_r      <= 1'b0;
        seg_draw_r    <= 1'b0;
        count_r       <= '0;
        ovf_r         <= 1'b0;
      end else if (counting) begin
        count_r <= count_r + CW'(1);
        // pushes, dropped on a full stack
        if ((push_live && !live_room) || (push_scope && !scope_room)) begin
          ovf_r <= 1'b1;
        end
        if (push_live && live_room) begin
          live_depth_r <= live_depth_r + DW'(1);
        end
        if (push_scope && scope_room) begin
          scope_depth_r <= scope_depth_r + SW'(1);
        end
        // end cuts the live stack back to the saved depth
        if (pop_scope) begin
          scope_depth_r <= scope_top;
          if (saved_depth < live_depth_r) begin
            live_depth_r <= saved_depth;
          end
        end
        if (op == OP_DRAW) begin
          seg_start_r  <= count_r + CW'(1);
          seg_view_r   <= item_view;
          seg_vv_r     <= 1'b1;
          seg_draw_r   <= 1'b0;
          snap_depth_r <= live_depth_r;
        end else if (op == OP_OTHER || op == OP_SPARE) begin
          seg_draw_r <= 1'b1;
        end
      end
    end
  end

  // stack contents
  always_ff @(posedge clk) begin
    if (accept && counting) begin
      for (int i = 0; i < STATE_DEPTH; i++) begin
        if (push_live && live_room && live_depth_r == DW'(i)) begin
          live_r[i] <= count_r[IW-1:0];
        end
      end
      for (int j = 0; j < SCOPE_DEPTH; j++) begin
        if (push_scope && scope_room && scope_depth_r == SW'(j)) begin
          scope_r[j] <= live_depth_r;
        end
      end
      if (op == OP_DRAW) begin
        snap_r <= live_r;
      end
    end
  end

endmodule

FILE: src/dls_back.sv
// back end: plays one segment job out as a header beat and saved index beats
module dls_back #(
  parameter int STATE_DEPTH = dls_pkg::DEF_STATE_DEPTH,
  parameter int MAX_ITEMS   = dls_pkg::DEF_MAX_ITEMS,
  localparam int CW  = $clog2(MAX_ITEMS + 1),
  localparam int IW  = $clog2(MAX_ITEMS),
  localparam int DW  = $clog2(STATE_DEPTH + 1),
  localparam int JW  = 2 * CW + dls_pkg::VIEW_W + 3 + DW + STATE_DEPTH * IW,
  localparam int OBW = 2 * CW + dls_pkg::VIEW_W + 3 + DW + IW,
  localparam int TDW = ((OBW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  logic [JW-1:0]  job_data,
  output logic           job_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [TDW-1:0] out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);
  import dls_pkg::*;

  typedef struct packed {
    logic [CW-1:0]                    start_index;
    logic [CW-1:0]                    end_index;
    logic [VIEW_W-1:0]                view;
    logic                             view_valid;
    logic                             drawing;
    logic [DW-1:0]                    count;
    logic                             ovf;
    logic [STATE_DEPTH-1:0][IW-1:0]   snap;
  } seg_job_t;

  dls_state_t     state_r;
  seg_job_t       job_r;
  seg_job_t       job_in;
  logic [DW-1:0]  rem_r;
  logic           adv;

  // output register
  logic              out_valid_r;
  logic              kind_r;
  logic [CW-1:0]     start_r;
  logic [CW-1:0]     end_r;
  logic [VIEW_W-1:0] view_r;
  logic              vv_r;
  logic              draw_r;
  logic [DW-1:0]     cnt_r;
  logic [IW-1:0]     sidx_r;
  logic              ovf_r;
  logic              last_r;

  assign job_in  = seg_job_t'(job_data);
  assign job_pop = (state_r == ST_IDLE) && job_valid;
  assign adv     = !out_valid_r || out_tready;

  // sequencer state and remaining saved index count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            state_r <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (adv) begin
            rem_r   <= job_r.count;
            state_r <= (job_r.count == '0) ? ST_IDLE : ST_BODY;
          end
        end
        ST_BODY: begin
          if (adv) begin
            rem_r <= rem_r - DW'(1);
            if (rem_r == DW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // job load and snapshot shift
  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_in;
    end else if (state_r == ST_BODY && adv) begin
      for (int i = 0; i < STATE_DEPTH - 1; i++) begin
        job_r.snap[i] <= job_r.snap[i + 1];
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= (state_r == ST_HEAD) || (state_r == ST_BODY);
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (adv && state_r == ST_HEAD) begin
      kind_r  <= KIND_HEADER;
      start_r <= job_r.start_index;
      end_r   <= job_r.end_index;
      view_r  <= job_r.view;
      vv_r    <= job_r.view_valid;
      draw_r  <= job_r.drawing;
      cnt_r   <= job_r.count;
      sidx_r  <= '0;
      ovf_r   <= job_r.ovf;
      last_r  <= (job_r.count == '0);
    end else if (adv && state_r == ST_BODY) begin
      kind_r  <= KIND_SAVED;
      start_r <= '0;
      end_r   <= '0;
      view_r  <= '0;
      vv_r    <= 1'b0;
      draw_r  <= 1'b0;
      cnt_r   <= '0;
      sidx_r  <= job_r.snap[0];
      ovf_r   <= job_r.ovf;
      last_r  <= (rem_r == DW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = TDW'({ovf_r, sidx_r, cnt_r, draw_r, vv_r, view_r, end_r, start_r});

`ifndef SYNTHESIS
  // a saved index run never sits at zero remaining
  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY) |-> (rem_r != '0))
    else $error("saved index run with nothing remaining");

  // a segment's final beat never leaves the sequencer mid run
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && last_r) |-> (state_r != ST_BODY))
    else $error("last beat delivered while saved indices still pending");

  // advancing in the run always places a saved index beat
  a_body_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY && adv) |=> (out_valid_r && kind_r == KIND_SAVED))
    else $error("saved index beat not produced");

  // a new job only starts once the previous one has fully left the sequencer
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == ST_HEAD))
    else $error("job taken but header not pending");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench for the display list segmenter: segment scoreboard, stream drivers and checks
module testbench;
  import dls_pkg::*;

  localparam int STATE_DEPTH = DEF_STATE_DEPTH;
  localparam int SCOPE_DEPTH = DEF_SCOPE_DEPTH;
  localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
  localparam int OUT_W       = 104;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 12;
  localparam longint TIMEOUT_NS = 64'd2_000_000;

  // one result beat, fields as the block defines them
  typedef struct packed {
    logic        kind;
    logic [20:0] start_index;
    logic [20:0] end_index;
    logic [31:0] preceding_view;
    logic        view_valid;
    logic        drawn;
    logic [4:0]  saved_count;
    logic [19:0] saved_index;
    logic        overflow;
    logic        last;
  } seg_beat_t;

  // segment scoreboard: tracks the list state and the beats still owed
  class seg_scoreboard;
    bit [19:0] live_stk [STATE_DEPTH];
    bit [4:0]  live_dp;
    bit [4:0]  scope_stk [SCOPE_DEPTH];
    bit [4:0]  scope_dp;
    bit [19:0] snap_stk [STATE_DEPTH];
    bit [4:0]  snap_dp;
    bit [20:0] seg_start;
    bit [31:0] seg_view;
    bit        seg_view_ok;
    bit        seg_draw;
    bit [20:0] item_cnt;
    bit        ovf;
    seg_beat_t beats_due [$];
    int        errors;

    function new();
      errors = 0;
      clear_list();
    endfunction

    function void clear_list();
      live_stk = '{default: 0};
      scope_stk = '{default: 0};
      snap_stk = '{default: 0};
      live_dp = 0;
      scope_dp = 0;
      snap_dp = 0;
      seg_start = 0;
      seg_view = 0;
      seg_view_ok = 0;
      seg_draw = 0;
      item_cnt = 0;
      ovf = 0;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void push_live(bit [19:0] idx);
      if (live_dp < STATE_DEPTH) begin
        live_stk[live_dp] = idx;
        live_dp++;
      end else begin
        ovf = 1;
      end
    endfunction

    // header followed by the indices snapshotted when the segment opened
    function void queue_segment(bit [20:0] end_idx);
      seg_beat_t b;
      int k;
      b = '0;
      b.kind = KIND_HEADER;
      b.start_index = seg_start;
      b.end_index = end_idx;
      b.preceding_view = seg_view;
      b.view_valid = seg_view_ok;
      b.drawn = seg_draw;
      b.saved_count = snap_dp;
      b.overflow = ovf;
      b.last = (snap_dp == 0);
      beats_due.insert(beats_due.size(), b);
      for (k = 0; k < snap_dp; k++) begin
        b = '0;
        b.kind = KIND_SAVED;
        b.saved_index = snap_stk[k];
        b.overflow = ovf;
        b.last = (k + 1 == snap_dp);
        beats_due.insert(beats_due.size(), b);
      end
    endfunction

    // advance the list state by one accepted opcode
    function void note_opcode(logic [2:0] op, logic [31:0] vid);
      bit [20:0] idx;
      bit [4:0]  saved;
      idx = item_cnt;
      if (op == OP_FINISH) begin
        if (item_cnt != 0) queue_segment(item_cnt);
        clear_list();
        return;
      end
      // counter full: everything but finish is dropped
      if (item_cnt >= MAX_ITEMS) return;
      item_cnt++;
      case (op)
        OP_BEGIN: begin
          if (scope_dp < SCOPE_DEPTH) begin
            scope_stk[scope_dp] = live_dp;
            scope_dp++;
          end else begin
            ovf = 1;
          end
          push_live(idx[19:0]);
        end
        OP_END: begin
          if (scope_dp > 0) begin
            scope_dp--;
            saved = scope_stk[scope_dp];
            if (saved < live_dp) live_dp = saved;
          end
        end
        OP_CLIP: push_live(idx[19:0]);
        OP_RECORD: ;
        OP_DRAW: begin
          queue_segment(idx);
          seg_start = idx + 1;
          seg_view = vid;
          seg_view_ok = 1;
          seg_draw = 0;
          snap_stk = live_stk;
          snap_dp = live_dp;
        end
        default: seg_draw = 1;
      endcase
    endfunction

    function void flag(string field, longint unsigned e, longint unsigned a);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, e, a);
      errors++;
    endfunction

    // compare one accepted beat against the oldest owed beat
    function void check_beat(seg_beat_t got);
      seg_beat_t want;
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      if (got.kind != want.kind) flag("kind", want.kind, got.kind);
      if (got.start_index != want.start_index)
        flag("start_index", want.start_index, got.start_index);
      if (got.end_index != want.end_index) flag("end_index", want.end_index, got.end_index);
      if (got.preceding_view != want.preceding_view)
        flag("preceding_view", want.preceding_view, got.preceding_view);
      if (got.view_valid != want.view_valid)
        flag("view_valid", want.view_valid, got.view_valid);
      if (got.drawn != want.drawn)
        flag("drawn", want.drawn, got.drawn);
      if (got.saved_count != want.saved_count)
        flag("saved_count", want.saved_count, got.saved_count);
      if (got.saved_index != want.saved_index)
        flag("saved_index", want.saved_index, got.saved_index);
      if (got.overflow != want.overflow) flag("overflow", want.overflow, got.overflow);
      if (got.last != want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [39:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  logic hold_req;
  logic no_gaps;
  int   burst_left;

  seg_scoreboard sb = new();

  display_list_segmenter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin : monitor
    seg_beat_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_opcode(in_tdata[2:0], in_tdata[34:3]);
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.start_index = out_tdata[20:0];
        got.end_index = out_tdata[41:21];
        got.preceding_view = out_tdata[73:42];
        got.view_valid = out_tdata[74];
        got.drawn = out_tdata[75];
        got.saved_count = out_tdata[80:76];
        got.saved_index = out_tdata[100:81];
        got.overflow = out_tdata[101];
        got.last = out_tlast;
        sb.check_beat(got);
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin : receiver
    int          pat_left;
    int          mode;
    logic [31:0] pat;
    bit          hold_done;
    out_tready = 1'b0;
    pat_left = 0;
    mode = 0;
    pat = '0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (pat_left == 0) begin
        pat = $urandom;
        mode = $urandom_range(0, 3);
        pat_left = $urandom_range(16, 64);
      end
      pat_left--;
      out_tready = (mode == 0) ? 1'b1 : pat[pat_left % 32];
    end
  end

  // one input beat, called at a falling edge, returns at a falling edge
  task automatic send_op(input logic [2:0] op, input logic [31:0] vid);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid = 1'b1;
    in_tdata = {5'b0, vid, op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_view();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // random lists: mostly ordinary opcode mixes, sometimes a deep push run
  task automatic random_lists(input int count);
    int sent;
    int r;
    int n;
    int i;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        n = $urandom_range(14, 20);
        for (i = 0; i < n; i++) send_op($urandom_range(0, 1) ? OP_BEGIN : OP_CLIP, $urandom);
        sent += n;
      end else begin
        if (r < 22) send_op(OP_BEGIN, $urandom);
        else if (r < 36) send_op(OP_END, $urandom);
        else if (r < 48) send_op(OP_CLIP, $urandom);
        else if (r < 53) send_op(OP_RECORD, $urandom);
        else if (r < 71) send_op(OP_DRAW, pick_view());
        else if (r < 89) send_op(OP_OTHER, $urandom);
        else if (r < 94) send_op(OP_SPARE, $urandom);
        else send_op(OP_FINISH, $urandom);
        sent++;
      end
    end
  endtask

  // directed opening: empty finish, empty scope end, both stacks overflowing, view extremes
  task automatic directed_lists();
    int i;
    send_op(OP_FINISH, 32'h0);
    send_op(OP_END, 32'h0);
    send_op(OP_OTHER, 32'h0);
    for (i = 0; i < 15; i++) send_op(OP_BEGIN, 32'h0);
    send_op(OP_CLIP, 32'h0);
    // scope push lands, live push dropped
    send_op(OP_BEGIN, 32'h0);
    // both pushes dropped
    send_op(OP_BEGIN, 32'h0);
    // saved depth equals live depth, nothing cut
    send_op(OP_END, 32'h0);
    send_op(OP_DRAW, 32'hFFFF_FFFF);
    send_op(OP_DRAW, 32'h0000_0000);
    send_op(OP_SPARE, 32'h0);
    send_op(OP_RECORD, 32'h0);
    send_op(OP_FINISH, 32'h0);
  endtask

  // main sequence
  initial begin : stimulus
    int i;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_lists();
    random_lists(50);

    // long receiver hold-off while the sender keeps offering segments
    hold_req = 1'b1;
    no_gaps = 1'b1;
    for (i = 0; i < 20; i++) send_op((i % 2 == 0) ? OP_CLIP : OP_DRAW, $urandom);
    send_op(OP_FINISH, 32'h0);
    no_gaps = 1'b0;

    // sender pause until every owed beat has come
    wait_drained();
    random_lists(50);
    send_op(OP_FINISH, 32'h0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
